// ----- rtl/traffic_light_phase_sequencer_assert.svh -----
// Assertion macros for the traffic light phase sequencer.
`ifndef TRAFFIC_LIGHT_PHASE_SEQUENCER_ASSERT_SVH
`define TRAFFIC_LIGHT_PHASE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define TLPS_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tlps check failed");
// Antecedent implies consequent in the same cycle.
`define TLPS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlps implication failed");
`else
`define TLPS_CHECK(lbl, cond)
`define TLPS_IMPLY(lbl, ante, cons)
`endif

`endif

// ----- rtl/tlps_pkg.sv -----
// Shared constants, types and helpers for the traffic light phase sequencer.
package tlps_pkg;

  localparam int DUR_W = 20;
  localparam int REM_W = 22;
  localparam int SPD_W = 8;
  localparam int CMD_W = 2;
  localparam int PH_W  = 3;
  localparam int IDX_W = 3;
  localparam int NUM_W = REM_W + SPD_W;
  localparam int DEN_W = REM_W;

  localparam logic [REM_W-1:0] REM_MAX  = {REM_W{1'b1}};
  localparam int               SEC_LIMIT = 1000;
  localparam int               BLINK_MS_DEF = 500;

  localparam logic [DUR_W-1:0] RED_RESET        = DUR_W'(58000);
  localparam logic [DUR_W-1:0] RED_YELLOW_RESET = DUR_W'(3000);
  localparam logic [DUR_W-1:0] GREEN_RESET      = DUR_W'(58000);
  localparam logic [DUR_W-1:0] YELLOW_RESET     = DUR_W'(1000);

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPEED = 2'd3;

  localparam logic [PH_W-1:0] PH_RED        = 3'd0;
  localparam logic [PH_W-1:0] PH_RED_YELLOW = 3'd1;
  localparam logic [PH_W-1:0] PH_GREEN      = 3'd2;
  localparam logic [PH_W-1:0] PH_YELLOW     = 3'd3;
  localparam logic [PH_W-1:0] PH_DARK       = 3'd4;

  localparam logic [IDX_W-1:0] REG_RED        = 3'd0;
  localparam logic [IDX_W-1:0] REG_RED_YELLOW = 3'd1;
  localparam logic [IDX_W-1:0] REG_GREEN      = 3'd2;
  localparam logic [IDX_W-1:0] REG_YELLOW     = 3'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  // x * 1000 as shifts: 1024x - 16x - 8x; x < 1000 so it fits 20 bits
  function automatic logic [DUR_W-1:0] times_1000(input logic [9:0] x);
    logic [DUR_W-1:0] xe;
    xe = DUR_W'(x);
    return (xe << 10) - (xe << 4) - (xe << 3);
  endfunction

  function automatic logic [REM_W-1:0] clip_rem(input logic [NUM_W-1:0] q);
    return (|q[NUM_W-1:REM_W]) ? REM_MAX : q[REM_W-1:0];
  endfunction

endpackage

// ----- rtl/tlps_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module tlps_div
  import tlps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] part_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] part_nxt;

  // partial remainder stays below the divisor, so trial < 2*den
  assign trial    = {part_r, quo_r[NUM_W-1]};
  assign diff     = trial - {1'b0, den_r};
  assign ge       = (trial >= {1'b0, den_r});
  assign part_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.num;
      part_r <= '0;
      den_r  <= req.den;
    end else if (busy_r) begin
      quo_r  <= {quo_r[NUM_W-2:0], ge};
      part_r <= part_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = part_r;

endmodule

// ----- rtl/traffic_light_phase_sequencer.sv -----
// Top level of the traffic light phase sequencer.
//
// Usage:
//  - Input channel (in_valid/in_stall): one command per transfer: tick (one ms),
//    start/resync at in_offset_ms, set active (in_active, in_resync), set speed.
//  - Result channel (out_valid/out_stall): exactly one result per command:
//    phase, pedestrian green, ticks left in the phase, phase-changed flag.
//  - Config channel (cfg_valid/cfg_ready): four phase durations, index 0..3;
//    higher indexes are dropped. cfg_ready is always high. Write only while idle.
// Sequencing: one command in flight at a time. A plain tick passes S_PREP and
//  S_EXEC to S_DONE. Any timer load runs the 30-step serial divider. A speed
//  change adds the 8-step serial multiply. A resync whose offset exceeds the
//  cycle runs the divider twice plus up to four accumulate steps. The divider
//  sets the rate.
// Reset (rst_n low, synchronous): phase dark, timer 0, speed 1, inactive, not
//  started, durations 58000/3000/58000/1000 ms.
// Stall: a finished result sits in the output register while out_stall is
//  high; the next command is taken meanwhile and waits at its end for the slot.
module traffic_light_phase_sequencer
  import tlps_pkg::*;
#(
  parameter int BLINK_MS = BLINK_MS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // command input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [REM_W-1:0] in_offset_ms,
  input  logic             in_active,
  input  logic             in_resync,
  input  logic [SPD_W-1:0] in_new_speed,
  // result output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PH_W-1:0]  out_phase,
  output logic             out_pedestrian_green,
  output logic [REM_W-1:0] out_remaining_ms,
  output logic             out_phase_changed,
  // config write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;  // lets the duration sums settle
  localparam logic [3:0] S_EXEC = 4'd2;  // command decode
  localparam logic [3:0] S_SYNC = 4'd3;  // offset range check
  localparam logic [3:0] S_ACC  = 4'd4;  // walk the phases, one per cycle
  localparam logic [3:0] S_SUB  = 4'd5;  // time left = running sum - offset
  localparam logic [3:0] S_MUL  = 4'd6;  // remaining * old speed, bit serial
  localparam logic [3:0] S_DIV  = 4'd7;  // launch divider
  localparam logic [3:0] S_WAIT = 4'd8;  // divider running
  localparam logic [3:0] S_DONE = 4'd9;  // hand result to output register

  localparam logic K_LOAD = 1'b0;  // quotient loads the timer
  localparam logic K_MOD  = 1'b1;  // remainder replaces the offset

  localparam int MCNT_W = $clog2(SPD_W);

  // ---------------- configuration and effective durations ----------------
  logic [DUR_W-1:0] dur_r [4];
  logic [REM_W-1:0] raw_sum_r;
  logic [REM_W-1:0] cycle_r;
  logic [DUR_W-1:0] eff_r [4];
  logic             in_seconds;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r[0] <= RED_RESET;
      dur_r[1] <= RED_YELLOW_RESET;
      dur_r[2] <= GREEN_RESET;
      dur_r[3] <= YELLOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED:        dur_r[0] <= cfg_data;
        REG_RED_YELLOW: dur_r[1] <= cfg_data;
        REG_GREEN:      dur_r[2] <= cfg_data;
        REG_YELLOW:     dur_r[3] <= cfg_data;
        default: ;  // no such register
      endcase
    end
  end

  // Two-stage pipe: raw sum, then seconds-vs-ms decision. It settles once both
  // stages have taken the last config write; S_PREP covers the gap.
  assign in_seconds = (raw_sum_r < REM_W'(SEC_LIMIT));

  always_ff @(posedge clk) begin
    raw_sum_r <= REM_W'(dur_r[0]) + REM_W'(dur_r[1]) + REM_W'(dur_r[2]) + REM_W'(dur_r[3]);
    cycle_r   <= in_seconds ? REM_W'(times_1000(raw_sum_r[9:0])) : raw_sum_r;
    for (int i = 0; i < 4; i++) begin
      eff_r[i] <= in_seconds ? times_1000(dur_r[i][9:0]) : dur_r[i];
    end
  end

  // ---------------- sequencer ----------------
  logic [3:0]        state_r, state_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [SPD_W-1:0]  speed_r, speed_nxt;
  logic              active_r, active_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [REM_W-1:0]  off_r, off_nxt;
  logic              act_r, act_nxt;
  logic              rs_r, rs_nxt;
  logic [SPD_W-1:0]  ns_r, ns_nxt;
  logic [PH_W-1:0]   before_r, before_nxt;
  logic [REM_W-1:0]  acc_r, acc_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              kind_r, kind_nxt;
  logic [SPD_W-1:0]  mul_sh_r, mul_sh_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PH_W-1:0]   out_phase_r, out_phase_nxt;
  logic [REM_W-1:0]  out_rem_r, out_rem_nxt;
  logic              out_chg_r, out_chg_nxt;

  logic [1:0]        next_ph;
  logic [1:0]        dur_sel;
  logic [DUR_W-1:0]  eff_rd;
  logic [REM_W-1:0]  acc_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tlps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // dark and yellow both wrap to red
  assign next_ph = (phase_r >= PH_YELLOW) ? PH_RED[1:0] : (phase_r[1:0] + 2'd1);
  // single read port on the duration table
  assign dur_sel = (state_r == S_ACC) ? idx_r : next_ph;
  assign eff_rd  = eff_r[dur_sel];
  assign acc_sum = acc_r + REM_W'(eff_rd);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    speed_nxt     = speed_r;
    active_nxt    = active_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    act_nxt       = act_r;
    rs_nxt        = rs_r;
    ns_nxt        = ns_r;
    before_nxt    = before_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    kind_nxt      = kind_r;
    mul_sh_nxt    = mul_sh_r;
    cnt_nxt       = cnt_r;
    out_phase_nxt = out_phase_r;
    out_rem_nxt   = out_rem_r;
    out_chg_nxt   = out_chg_r;
    div_req.start = 1'b0;
    div_req.num   = num_r;
    div_req.den   = den_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          off_nxt    = in_offset_ms;
          act_nxt    = in_active;
          rs_nxt     = in_resync;
          ns_nxt     = in_new_speed;
          before_nxt = phase_r;
          state_nxt  = S_PREP;
        end
      end

      S_PREP: state_nxt = S_EXEC;

      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_TICK: begin
            if (started_r) begin
              if (rem_r > REM_W'(1)) begin
                rem_nxt = rem_r - REM_W'(1);
              end else if (active_r) begin
                // expiry: advance and load the new phase's length
                phase_nxt = {1'b0, next_ph};
                num_nxt   = NUM_W'(eff_rd);
                den_nxt   = DEN_W'(speed_r);
                kind_nxt  = K_LOAD;
                state_nxt = S_DIV;
              end else begin
                phase_nxt = (phase_r == PH_DARK) ? PH_YELLOW : PH_DARK;
                num_nxt   = NUM_W'(BLINK_MS);
                den_nxt   = DEN_W'(speed_r);
                kind_nxt  = K_LOAD;
                state_nxt = S_DIV;
              end
            end
          end
          CMD_START: begin
            started_nxt = 1'b1;
            if (active_r) begin
              state_nxt = S_SYNC;
            end else begin
              num_nxt   = NUM_W'(BLINK_MS);
              den_nxt   = DEN_W'(speed_r);
              kind_nxt  = K_LOAD;
              state_nxt = S_DIV;
            end
          end
          CMD_ACT: begin
            if (act_r != active_r) begin
              active_nxt = act_r;
              if (act_r) begin
                if (started_r && rs_r) begin
                  off_nxt   = '0;
                  state_nxt = S_SYNC;
                end
              end else if (started_r) begin
                phase_nxt = PH_DARK;
                num_nxt   = NUM_W'(BLINK_MS);
                den_nxt   = DEN_W'(speed_r);
                kind_nxt  = K_LOAD;
                state_nxt = S_DIV;
              end
            end
          end
          CMD_SPEED: begin
            if (ns_r != '0) begin
              speed_nxt = ns_r;
              if (started_r) begin
                num_nxt    = '0;
                mul_sh_nxt = speed_r;
                cnt_nxt    = '0;
                den_nxt    = DEN_W'(ns_r);
                kind_nxt   = K_LOAD;
                state_nxt  = S_MUL;
              end
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_SYNC: begin
        acc_nxt = '0;
        idx_nxt = '0;
        if (off_r > cycle_r) begin
          if (cycle_r == '0) begin
            off_nxt   = '0;
            state_nxt = S_ACC;
          end else begin
            num_nxt   = NUM_W'(off_r);
            den_nxt   = cycle_r;
            kind_nxt  = K_MOD;
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_ACC;
        end
      end

      S_ACC: begin
        // offset <= cycle here, so the last phase always hits
        acc_nxt = acc_sum;
        if (off_r <= acc_sum) begin
          phase_nxt = {1'b0, idx_r};
          state_nxt = S_SUB;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      S_SUB: begin
        num_nxt   = NUM_W'(acc_r - off_r);
        den_nxt   = DEN_W'(speed_r);
        kind_nxt  = K_LOAD;
        state_nxt = S_DIV;
      end

      S_MUL: begin
        // MSB-first shift-add of the old speed
        num_nxt    = {num_r[NUM_W-2:0], 1'b0}
                   + (mul_sh_r[SPD_W-1] ? NUM_W'(rem_r) : '0);
        mul_sh_nxt = {mul_sh_r[SPD_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + MCNT_W'(1);
        if (cnt_r == MCNT_W'(SPD_W - 1)) begin
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = S_WAIT;
      end

      S_WAIT: begin
        if (div_rsp.done) begin
          if (kind_r == K_MOD) begin
            off_nxt   = div_rsp.rem;
            acc_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = S_ACC;
          end else begin
            rem_nxt   = clip_rem(div_rsp.quo);
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_phase_nxt = phase_r;
          out_rem_nxt   = rem_r;
          out_chg_nxt   = (phase_r != before_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DARK;
      rem_r       <= '0;
      speed_r     <= SPD_W'(1);
      active_r    <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      speed_r     <= speed_nxt;
      active_r    <= active_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    off_r       <= off_nxt;
    act_r       <= act_nxt;
    rs_r        <= rs_nxt;
    ns_r        <= ns_nxt;
    before_r    <= before_nxt;
    acc_r       <= acc_nxt;
    idx_r       <= idx_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    kind_r      <= kind_nxt;
    mul_sh_r    <= mul_sh_nxt;
    cnt_r       <= cnt_nxt;
    out_phase_r <= out_phase_nxt;
    out_rem_r   <= out_rem_nxt;
    out_chg_r   <= out_chg_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = out_phase_r;
  assign out_pedestrian_green = (out_phase_r == PH_RED);
  assign out_remaining_ms     = out_rem_r;
  assign out_phase_changed    = out_chg_r;

  // ---------------- assertions ----------------
`include "traffic_light_phase_sequencer_assert.svh"

  `TLPS_CHECK(a_speed_nonzero, speed_r != '0)
  `TLPS_CHECK(a_phase_in_range, phase_r <= PH_DARK)
  `TLPS_IMPLY(a_div_done_when_waiting, div_rsp.done, state_r == S_WAIT)
  `TLPS_IMPLY(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
